FILE: rtl/core/euler_to_camera_basis_macros.svh
// assertion macros for the camera basis block
`ifndef EULER_TO_CAMERA_BASIS_MACROS_SVH
`define EULER_TO_CAMERA_BASIS_MACROS_SVH

// same-cycle implication, disabled during reset
`define ETCB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ETCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/etcb_pkg.sv
// ----------------------------------------------------------------------------
// etcb_pkg
// Shared widths, CORDIC angle table and fixed-point helpers for the
// camera basis pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package etcb_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int FRAC_BITS    = 14;
   localparam int OUT_BITS     = 16;
   localparam int Q_BITS       = 30;
   localparam int CORDIC_STEPS = 30;
   localparam int STEPS_PER_ST = 2;
   localparam int ITER_STAGES  = CORDIC_STEPS / STEPS_PER_ST;
   // fold stage, iteration stages, quadrant stage
   localparam int CORDIC_LAT   = ITER_STAGES + 2;
   // after the CORDIC: products, up vector, cross products, output
   localparam int NUM_STAGES   = CORDIC_LAT + 4;
   localparam int CW           = 34;
   localparam int SC_BITS      = 32;
   localparam int UV_BITS      = 33;
   localparam int XP_BITS      = 66;

   localparam logic signed [CW-1:0] CORDIC_GAIN_START = 34'sd652032874;

   localparam longint ONE_VAL = longint'(1) << FRAC_BITS;
   localparam longint POS_VAL = (ONE_VAL > 32767) ? 32767 : ONE_VAL;
   localparam longint NEG_VAL = (ONE_VAL > 32768) ? -32768 : -ONE_VAL;
   localparam logic signed [XP_BITS:0] POS_LIM = (XP_BITS+1)'(POS_VAL);
   localparam logic signed [XP_BITS:0] NEG_LIM = (XP_BITS+1)'(NEG_VAL);

   typedef logic signed [SC_BITS-1:0] sc_type;
   typedef logic signed [OUT_BITS-1:0] out_type;

   function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051D;
         5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2E;
         5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F;  5'd19: v = 32'h00000517;
         5'd20: v = 32'h0000028B;  5'd21: v = 32'h00000145;
         5'd22: v = 32'h000000A2;  5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000028;  5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000002;  5'd29: v = 32'h00000001;
         default: v = 32'h0;
      endcase
      return $signed({2'b00, v});
   endfunction

   // Q2.30 product rounded half up back to Q2.30
   function automatic sc_type qmul(input sc_type a, input sc_type b);
      logic signed [2*SC_BITS-1:0] p;
      p = a * b;
      p = p + (64'sd1 <<< (Q_BITS - 1));
      return p[Q_BITS+SC_BITS-1:Q_BITS];
   endfunction

   // round half up from s fraction bits down to FRAC_BITS, clamp to +-1.0
   function automatic out_type to_field(input logic signed [XP_BITS-1:0] v, input int s);
      logic signed [XP_BITS:0] r;
      r = ($signed({v[XP_BITS-1], v}) + ((XP_BITS+1)'(1) <<< (s - FRAC_BITS - 1)))
          >>> (s - FRAC_BITS);
      if (r > POS_LIM) r = POS_LIM;
      if (r < NEG_LIM) r = NEG_LIM;
      return r[OUT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/etcb_cordic.sv
// ----------------------------------------------------------------------------
// etcb_cordic
// Pipelined sine/cosine: quadrant fold, two CORDIC rotations per stage,
// quadrant restore. Each stage loads when its enable is high.
// ----------------------------------------------------------------------------
`default_nettype none

module etcb_cordic (
   input  wire logic                                   clock,
   input  wire logic [etcb_pkg::CORDIC_LAT-1:0]        stage_en,
   input  wire logic [etcb_pkg::ANGLE_BITS-1:0]        angle,
   output etcb_pkg::sc_type                            sin_out,
   output etcb_pkg::sc_type                            cos_out
);
   import etcb_pkg::*;

   logic signed [CW-1:0] x_ff [ITER_STAGES+1];
   logic signed [CW-1:0] y_ff [ITER_STAGES+1];
   logic signed [CW-1:0] z_ff [ITER_STAGES+1];
   logic [1:0]           q_ff [ITER_STAGES+1];

   logic [31:0]          turn;
   logic [31:0]          turn_ofs;
   logic [1:0]           quad;
   logic [31:0]          dlt;

   assign turn     = {angle, {(32-ANGLE_BITS){1'b0}}};
   assign turn_ofs = turn + 32'h20000000;
   assign quad     = turn_ofs[31:30];
   assign dlt      = turn - {quad, 30'b0};

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff[0] <= CORDIC_GAIN_START;
         y_ff[0] <= '0;
         z_ff[0] <= $signed({{(CW-32){dlt[31]}}, dlt});
         q_ff[0] <= quad;
      end
   end

   for (genvar k = 1; k <= ITER_STAGES; k++) begin : g_iter
      logic signed [CW-1:0] x_in, y_in, z_in;

      always_comb begin
         logic signed [CW-1:0] xs, ys, xt, yt, zt;
         xt = x_ff[k-1];
         yt = y_ff[k-1];
         zt = z_ff[k-1];
         for (int j = 0; j < STEPS_PER_ST; j++) begin
            xs = xt >>> ((k-1)*STEPS_PER_ST + j);
            ys = yt >>> ((k-1)*STEPS_PER_ST + j);
            if (!zt[CW-1]) begin
               xt = xt - ys;
               yt = yt + xs;
               zt = zt - atan_turn(5'((k-1)*STEPS_PER_ST + j));
            end else begin
               xt = xt + ys;
               yt = yt - xs;
               zt = zt + atan_turn(5'((k-1)*STEPS_PER_ST + j));
            end
         end
         x_in = xt;
         y_in = yt;
         z_in = zt;
      end

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            x_ff[k] <= x_in;
            y_ff[k] <= y_in;
            z_ff[k] <= z_in;
            q_ff[k] <= q_ff[k-1];
         end
      end
   end

   sc_type xe, ye, sin_in, cos_in, sin_ff, cos_ff;
   assign xe = x_ff[ITER_STAGES][SC_BITS-1:0];
   assign ye = y_ff[ITER_STAGES][SC_BITS-1:0];

   always_comb begin
      case (q_ff[ITER_STAGES])
         2'd0:    begin cos_in = xe;  sin_in = ye;  end
         2'd1:    begin cos_in = -ye; sin_in = xe;  end
         2'd2:    begin cos_in = -xe; sin_in = -ye; end
         default: begin cos_in = ye;  sin_in = -xe; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[CORDIC_LAT-1]) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

`default_nettype wire

FILE: rtl/core/euler_to_camera_basis.sv
// an accepted item moves through the cordic, product, up, cross and output stages
// throughput: one item per cycle unless rsp is held; 21 stages (17 in the cordic)
// stalls back up stage by stage; empty stages still fill while rsp is held
// reset clears all stage valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// euler_to_camera_basis
// Pitch/yaw/roll binary angles to camera forward, up and side vectors in
// Q1.14, with three pipelined CORDIC units and a product/cross pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "euler_to_camera_basis_macros.svh"

module euler_to_camera_basis (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [etcb_pkg::ANGLE_BITS-1:0]    req_pitch_angle,
   input  wire logic [etcb_pkg::ANGLE_BITS-1:0]    req_yaw_angle,
   input  wire logic [etcb_pkg::ANGLE_BITS-1:0]    req_roll_angle,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output etcb_pkg::out_type                       rsp_fwd_x,
   output etcb_pkg::out_type                       rsp_fwd_y,
   output etcb_pkg::out_type                       rsp_fwd_z,
   output etcb_pkg::out_type                       rsp_up_x,
   output etcb_pkg::out_type                       rsp_up_y,
   output etcb_pkg::out_type                       rsp_up_z,
   output etcb_pkg::out_type                       rsp_side_x,
   output etcb_pkg::out_type                       rsp_side_y,
   output etcb_pkg::out_type                       rsp_side_z
);
   import etcb_pkg::*;

   localparam int SA = CORDIC_LAT;
   localparam int SB = CORDIC_LAT + 1;
   localparam int SC = CORDIC_LAT + 2;
   localparam int SD = CORDIC_LAT + 3;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] adv;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int j = NUM_STAGES-2; j >= 0; j--) begin
         adv[j] = !vld_ff[j] || adv[j+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int j = 0; j < NUM_STAGES; j++) begin
            if (adv[j]) begin
               vld_ff[j] <= (j == 0) ? req_valid : vld_ff[(j == 0) ? 0 : j-1];
            end
         end
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   sc_type sp, cp, sy, cy, sr, cr;

   etcb_cordic u_pitch (.clock(clock), .stage_en(adv[CORDIC_LAT-1:0]),
                        .angle(req_pitch_angle), .sin_out(sp), .cos_out(cp));
   etcb_cordic u_yaw   (.clock(clock), .stage_en(adv[CORDIC_LAT-1:0]),
                        .angle(req_yaw_angle), .sin_out(sy), .cos_out(cy));
   etcb_cordic u_roll  (.clock(clock), .stage_en(adv[CORDIC_LAT-1:0]),
                        .angle(req_roll_angle), .sin_out(sr), .cos_out(cr));

   // stage a: first products
   sc_type a_fx_ff, a_fy_ff, a_fz_ff, a_t_ff, a_uy_ff, a_m1_ff, a_m2_ff;
   sc_type a_sy_ff, a_cy_ff;

   always_ff @(posedge clock) begin
      if (adv[SA]) begin
         a_fx_ff <= qmul(sy, cp);
         a_fy_ff <= sp;
         a_fz_ff <= -qmul(cp, cy);
         a_t_ff  <= qmul(sp, cr);
         a_uy_ff <= qmul(cp, cr);
         a_m1_ff <= qmul(cy, sr);
         a_m2_ff <= qmul(sy, sr);
         a_sy_ff <= sy;
         a_cy_ff <= cy;
      end
   end

   // stage b: up vector
   sc_type b_fx_ff, b_fy_ff, b_fz_ff, b_uy_ff;
   logic signed [UV_BITS-1:0] b_ux_ff, b_uz_ff, b_ux_in, b_uz_in;
   sc_type pb1, pb2;

   assign pb1 = qmul(a_sy_ff, a_t_ff);
   assign pb2 = qmul(a_cy_ff, a_t_ff);
   assign b_ux_in = -UV_BITS'(a_m1_ff) - UV_BITS'(pb1);
   assign b_uz_in = -UV_BITS'(a_m2_ff) + UV_BITS'(pb2);

   always_ff @(posedge clock) begin
      if (adv[SB]) begin
         b_fx_ff <= a_fx_ff;
         b_fy_ff <= a_fy_ff;
         b_fz_ff <= a_fz_ff;
         b_uy_ff <= a_uy_ff;
         b_ux_ff <= b_ux_in;
         b_uz_ff <= b_uz_in;
      end
   end

   // stage c: cross-product terms
   logic signed [XP_BITS-1:0] c_p_ff [6];
   sc_type c_fx_ff, c_fy_ff, c_fz_ff, c_uy_ff;
   logic signed [UV_BITS-1:0] c_ux_ff, c_uz_ff;
   logic signed [UV_BITS-1:0] fx_e, fy_e, fz_e, uy_e;

   assign fx_e = UV_BITS'(b_fx_ff);
   assign fy_e = UV_BITS'(b_fy_ff);
   assign fz_e = UV_BITS'(b_fz_ff);
   assign uy_e = UV_BITS'(b_uy_ff);

   always_ff @(posedge clock) begin
      if (adv[SC]) begin
         c_p_ff[0] <= fy_e * b_uz_ff;
         c_p_ff[1] <= fz_e * uy_e;
         c_p_ff[2] <= fz_e * b_ux_ff;
         c_p_ff[3] <= fx_e * b_uz_ff;
         c_p_ff[4] <= fx_e * uy_e;
         c_p_ff[5] <= fy_e * b_ux_ff;
         c_fx_ff   <= b_fx_ff;
         c_fy_ff   <= b_fy_ff;
         c_fz_ff   <= b_fz_ff;
         c_uy_ff   <= b_uy_ff;
         c_ux_ff   <= b_ux_ff;
         c_uz_ff   <= b_uz_ff;
      end
   end

   // stage d: round, clamp, output register
   out_type fwd_x_ff, fwd_y_ff, fwd_z_ff, up_x_ff, up_y_ff, up_z_ff;
   out_type side_x_ff, side_y_ff, side_z_ff;

   always_ff @(posedge clock) begin
      if (adv[SD]) begin
         fwd_x_ff  <= to_field(XP_BITS'(c_fx_ff), Q_BITS);
         fwd_y_ff  <= to_field(XP_BITS'(c_fy_ff), Q_BITS);
         fwd_z_ff  <= to_field(XP_BITS'(c_fz_ff), Q_BITS);
         up_x_ff   <= to_field(XP_BITS'(c_ux_ff), Q_BITS);
         up_y_ff   <= to_field(XP_BITS'(c_uy_ff), Q_BITS);
         up_z_ff   <= to_field(XP_BITS'(c_uz_ff), Q_BITS);
         side_x_ff <= to_field(c_p_ff[0] - c_p_ff[1], 2*Q_BITS);
         side_y_ff <= to_field(c_p_ff[2] - c_p_ff[3], 2*Q_BITS);
         side_z_ff <= to_field(c_p_ff[4] - c_p_ff[5], 2*Q_BITS);
      end
   end

   assign rsp_fwd_x  = fwd_x_ff;
   assign rsp_fwd_y  = fwd_y_ff;
   assign rsp_fwd_z  = fwd_z_ff;
   assign rsp_up_x   = up_x_ff;
   assign rsp_up_y   = up_y_ff;
   assign rsp_up_z   = up_z_ff;
   assign rsp_side_x = side_x_ff;
   assign rsp_side_y = side_y_ff;
   assign rsp_side_z = side_z_ff;

   `ETCB_ASSERT_NOW(a_empty_out_ready, clock, reset, !rsp_valid, req_ready,
      "input stalled with empty output stage")
   `ETCB_ASSERT_NOW(a_fwd_y_range, clock, reset, rsp_valid,
      (rsp_fwd_y <= 16'sd16384) && (rsp_fwd_y >= -16'sd16384), "fwd_y out of range")
   `ETCB_ASSERT_NOW(a_side_z_range, clock, reset, rsp_valid,
      (rsp_side_z <= 16'sd16384) && (rsp_side_z >= -16'sd16384), "side_z out of range")
   `ETCB_ASSERT_NEXT(a_hold_stall, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_up_x) && $stable(rsp_side_x), "stalled result changed")

endmodule

`default_nettype wire

FILE: dv/tb_euler_to_camera_basis.sv
// ----------------------------------------------------------------------------
// tb_euler_to_camera_basis
// Drives pitch/yaw/roll items with random gaps and random result stalls, and
// checks every camera basis result against a bit-exact CORDIC predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_euler_to_camera_basis;
   timeunit 1ns;
   timeprecision 1ps;

   import etcb_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] pitch;
      logic [ANGLE_BITS-1:0] yaw;
      logic [ANGLE_BITS-1:0] roll;
   } angles_type;

   typedef struct packed {
      logic [15:0] fx, fy, fz, ux, uy, uz, sx, sy, sz;
   } basis_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ANGLE_BITS-1:0] req_pitch_angle = '0;
   logic [ANGLE_BITS-1:0] req_yaw_angle = '0;
   logic [ANGLE_BITS-1:0] req_roll_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   out_type rsp_fwd_x, rsp_fwd_y, rsp_fwd_z, rsp_up_x, rsp_up_y, rsp_up_z;
   out_type rsp_side_x, rsp_side_y, rsp_side_z;

   angles_type pending_angles[$];
   int         hold_marks[$];   // item index before which the sender drains
   basis_type  expected_basis[$];
   int         error_count = 0;
   int         sent_count = 0;
   bit         stimulus_done = 1'b0;
   int         idle_cycles = 0;

   euler_to_camera_basis dut (.*);

   always #6 clock = ~clock;

   function automatic longint floor_sh(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_sh(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      return round_sh(a * b, Q_BITS);
   endfunction

   // side vector products need up to 66 bits
   function automatic logic [15:0] clamp_out(logic signed [69:0] v, int s);
      logic signed [69:0] r;
      logic signed [69:0] one;
      one = 70'sd1 <<< FRAC_BITS;
      r = (s == 0) ? v : ((v + (70'sd1 <<< (s - 1))) >>> s);
      if (r > one) r = one;
      if (r < -one) r = -one;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic void cordic_sincos(input logic [ANGLE_BITS-1:0] raw,
                                         output longint sn, output longint cs);
      logic [31:0] a, d;
      logic [1:0]  quad;
      longint x, y, z, xs, ys;
      logic [31:0] atn [30];
      atn = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
              32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
              32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
              32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};
      a = 32'(raw) << (32 - ANGLE_BITS);
      quad = 2'((a + 32'h20000000) >> 30);
      d = a - (32'(quad) << 30);
      z = d[31] ? longint'(d) - (longint'(1) << 32) : longint'(d);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         xs = floor_sh(x, i);
         ys = floor_sh(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(atn[i]);
         end else begin
            x += ys; y -= xs; z += longint'(atn[i]);
         end
      end
      case (quad)
         2'd0: begin cs = x;  sn = y;  end
         2'd1: begin cs = -y; sn = x;  end
         2'd2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endfunction

   function automatic basis_type predict_basis(angles_type ang);
      longint sp, cp, sy, cy, sr, cr, fx, fy, fz, ux, uy, uz, t;
      logic signed [69:0] wfx, wfy, wfz, wux, wuy, wuz;
      basis_type b;
      cordic_sincos(ang.pitch, sp, cp);
      cordic_sincos(ang.yaw, sy, cy);
      cordic_sincos(ang.roll, sr, cr);
      fx = fx_mul(sy, cp);
      fy = sp;
      fz = -fx_mul(cp, cy);
      t  = fx_mul(sp, cr);
      ux = -fx_mul(cy, sr) - fx_mul(sy, t);
      uy = fx_mul(cp, cr);
      uz = -fx_mul(sy, sr) + fx_mul(cy, t);
      wfx = fx; wfy = fy; wfz = fz; wux = ux; wuy = uy; wuz = uz;
      b.fx = clamp_out(wfx, Q_BITS - FRAC_BITS);
      b.fy = clamp_out(wfy, Q_BITS - FRAC_BITS);
      b.fz = clamp_out(wfz, Q_BITS - FRAC_BITS);
      b.ux = clamp_out(wux, Q_BITS - FRAC_BITS);
      b.uy = clamp_out(wuy, Q_BITS - FRAC_BITS);
      b.uz = clamp_out(wuz, Q_BITS - FRAC_BITS);
      b.sx = clamp_out(wfy * wuz - wfz * wuy, 2 * Q_BITS - FRAC_BITS);
      b.sy = clamp_out(wfz * wux - wfx * wuz, 2 * Q_BITS - FRAC_BITS);
      b.sz = clamp_out(wfx * wuy - wfy * wux, 2 * Q_BITS - FRAC_BITS);
      return b;
   endfunction

   function automatic logic [ANGLE_BITS-1:0] pick_angle();
      logic [ANGLE_BITS-1:0] quarter;
      quarter = ANGLE_BITS'(1 << (ANGLE_BITS - 2));
      case ($urandom_range(0, 3))
         0: return ANGLE_BITS'(quarter * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
         default: return ANGLE_BITS'($urandom());
      endcase
   endfunction

   initial begin
      angles_type a;
      logic [ANGLE_BITS-1:0] dir [10];
      dir = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
              16'h3FFF, 16'h7FFF, 16'h8001, 16'h5555};
      for (int i = 0; i < 10; i++) begin
         a.pitch = dir[i]; a.yaw = dir[(i + 3) % 10]; a.roll = dir[(i + 7) % 10];
         pending_angles.push_back(a);
      end
      a = '{16'hFFFF, 16'hFFFF, 16'hFFFF}; pending_angles.push_back(a);
      a = '{16'h4000, 16'h4000, 16'h4000}; pending_angles.push_back(a);
      a = '{16'hC000, 16'h8000, 16'h4000}; pending_angles.push_back(a);
      for (int i = 0; i < 1500; i++) begin
         a.pitch = pick_angle(); a.yaw = pick_angle(); a.roll = pick_angle();
         pending_angles.push_back(a);
      end
      hold_marks.push_back(13);
      hold_marks.push_back(700);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_basis.push_back(predict_basis(
               {req_pitch_angle, req_yaw_angle, req_roll_angle}));
            sent_count++;
            send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         end
         if (!req_valid || req_ready) begin
            if (pending_angles.size() == 0) begin
               req_valid <= 1'b0;
               stimulus_done = 1'b1;
            end else if (hold_marks.size() != 0 && sent_count == hold_marks[0]) begin
               // drain everything before going on
               req_valid <= 1'b0;
               if (expected_basis.size() == 0) void'(hold_marks.pop_front());
            end else if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else begin
               angles_type a;
               a = pending_angles.pop_front();
               req_valid <= 1'b1;
               req_pitch_angle <= a.pitch;
               req_yaw_angle <= a.yaw;
               req_roll_angle <= a.roll;
               send_gap = -1;
            end
         end
      end
   end

   task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name,
                  $signed(exp_v), $signed(act_v));
         error_count++;
      end
   endtask

   // monitor
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_valid && req_ready) idle_cycles = 0;
         if (rsp_valid && rsp_ready) begin
            basis_type e;
            idle_cycles = 0;
            if (expected_basis.size() == 0) begin
               $display("%0t unexpected result, expected none actual fwd_x %0d",
                        $time, rsp_fwd_x);
               error_count++;
            end else begin
               e = expected_basis.pop_front();
               check_field("fwd_x", e.fx, rsp_fwd_x);
               check_field("fwd_y", e.fy, rsp_fwd_y);
               check_field("fwd_z", e.fz, rsp_fwd_z);
               check_field("up_x", e.ux, rsp_up_x);
               check_field("up_y", e.uy, rsp_up_y);
               check_field("up_z", e.uz, rsp_up_z);
               check_field("side_x", e.sx, rsp_side_x);
               check_field("side_y", e.sy, rsp_side_y);
               check_field("side_z", e.sz, rsp_side_z);
            end
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      wait (stimulus_done);
      while (expected_basis.size() != 0 && idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      if (idle_cycles < WATCHDOG_LIMIT) repeat (3 * CORDIC_LAT + 20) @(posedge clock);
      if (error_count == 0 && idle_cycles < WATCHDOG_LIMIT) begin
         $display("tb_euler_to_camera_basis: done, clean");
      end else begin
         $display("tb_euler_to_camera_basis: done, errors");
      end
      $finish;
   end

   // watchdog for a hung pipeline
   initial begin
      wait (!reset);
      while (idle_cycles < WATCHDOG_LIMIT || stimulus_done) begin
         @(posedge clock);
         if (stimulus_done) break;
      end
      if (!stimulus_done) begin
         $display("tb_euler_to_camera_basis: done, errors");
         $finish;
      end
   end

endmodule

`default_nettype wire
